>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (pre) |-> (post), msg)

`endif

>>> sv/bes_pkg.sv
// Types and constants for the burst event scheduler.
// No dependencies.
`default_nettype none
package bes_pkg;

	localparam int unsigned DVW = 9;          // divisor width of the shared divider
	localparam int unsigned DDW = 32;         // dividend width
	localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
	localparam logic [15:0] MS_PER_MIN = 16'd60000;
	localparam logic [6:0] PCT_HALF = 7'd50;
	// floor(x / 100) = (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^23
	localparam logic [23:0] PCT_RECIP = 24'd10737419;
	localparam int unsigned PCT_SHIFT = 30;

	typedef enum logic [1:0] {
		OP_BUILD   = 2'd0,
		OP_STROKE  = 2'd1,
		OP_TIME    = 2'd2,
		OP_ADVANCE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_STROKES = 2'd1,
		KIND_CLOCK   = 2'd2,
		KIND_CADENCE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_STROKES = 2'd0,
		MODE_MINUTES = 2'd1,
		MODE_ENDLESS = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_MODE   = 2'd1,
		REG_LENGTH = 2'd2,
		REG_SHARE  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_SPAN   = 2'd0,
		DIV_STRIDE = 2'd1
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CNT_WAIT,
		S_SPAN_GO,
		S_SPAN_WAIT,
		S_FILL,
		S_STR_WAIT,
		S_CHECK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic     ready;
		logic     load;
		logic     clear;
		logic     div_start;
		div_sel_t div_sel;
		logic     set_count;
		logic     fill_init;
		logic     fill_step;
		logic     set_plan;
		logic     set_stride;
		logic     mem_read;
		logic     check;
		logic     advance;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		op_t   op;
		mode_t mode;
		logic  skip;
		logic  len_zero;
		logic  div_done;
		logic  cnt_zero;
		logic  fill_last;
		logic  out_free;
	} status_t;

endpackage
`default_nettype wire

>>> sv/bes_if.sv
// Request and result channel interfaces.
// Depends on nothing.
`default_nettype none
interface bes_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [30:0] strokes_done;
	logic [31:0] start_ms;
	logic [31:0] current_ms;
	modport source (output valid, op, strokes_done, start_ms, current_ms, input ready);
	modport sink (input valid, op, strokes_done, start_ms, current_ms, output ready);
endinterface

interface bes_result_if;
	logic       valid;
	logic       ready;
	logic       trigger;
	logic       plan_active;
	logic [1:0] plan_kind;
	logic [6:0] next_event_index;
	logic [6:0] event_total;
	modport source (output valid, trigger, plan_active, plan_kind, next_event_index,
		event_total, input ready);
	modport sink (input valid, trigger, plan_active, plan_kind, next_event_index,
		event_total, output ready);
endinterface
`default_nettype wire

>>> sv/burst_event_scheduler.sv
// Burst event scheduler, top level: controller plus datapath.
// Depends on bes_pkg, bes_if, bes_controller, bes_datapath.
//
// One request is in work at a time. From acceptance, an advance request passes
// decode and emit, a check request decode (which issues the table read), compare
// and emit. A build that leaves the plan cleared (disabled, zero share, zero
// length in a milestone mode, mode none) goes from decode to emit, through the
// count step too when the rounded count is zero; the count comes from a reciprocal
// multiply of the registered length-times-share product. A cadence build runs
// the shared one-bit-per-cycle divider once. A milestone build runs it once for
// the span and then writes one milestone per cycle. The next request is taken
// the cycle after the result is registered. The result register frees the request
// side: a new request is taken while the last result is still waiting, and the
// sequencer holds only if a second result would overwrite it. The milestone
// table is a RAM that holds no reset value; only entries written by the last
// build are ever used. The user must write configuration through cfg_we /
// cfg_index / cfg_data while idle (not enforced); writes take effect at once.
`default_nettype none
module burst_event_scheduler import bes_pkg::*; #(
	parameter int unsigned MAX_EVENTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	bes_item_if.sink         item,
	bes_result_if.source     result
);
	cmd_t    cmd;
	status_t sts;

	// sequencer: one state per step of a request
	bes_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	// plan state, divider, milestone RAM and result register
	bes_datapath #(.MAX_EVENTS(MAX_EVENTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.result    (result),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
`default_nettype wire

>>> sv/bes_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module bes_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [AW-1:0]          waddr,
	input  wire logic [WIDTH-1:0]       wdata,
	input  wire logic                   re,
	input  wire logic [AW-1:0]          raddr,
	output logic      [WIDTH-1:0]       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> sv/bes_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bes_pkg.
`default_nettype none
module bes_divider import bes_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DDW-1:0] dividend,
	input  wire logic [DVW-1:0] divisor,
	output logic                done,
	output logic     [DDW-1:0]  quotient,
	output logic     [DVW-1:0]  remainder
);
	localparam int unsigned CNTW = $clog2(DDW + 1);

	logic [DDW-1:0]  quo_q;
	logic [DVW-1:0]  rem_q;
	logic [DVW-1:0]  div_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DVW:0]    trial;
	logic            fits;

	assign trial = {rem_q, quo_q[DDW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DDW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DDW-2:0], fits};
			rem_q <= fits ? DVW'(trial - {1'b0, div_q}) : DVW'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

>>> sv/bes_datapath.sv
// Datapath: configuration registers, plan state, milestone table, divider, result register.
// Depends on bes_pkg, bes_if, bes_ram, bes_divider.
`default_nettype none
module bes_datapath import bes_pkg::*; #(
	parameter int unsigned MAX_EVENTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	bes_item_if.sink         item,
	bes_result_if.source     result,
	input  wire cmd_t        cmd,
	output status_t          sts
);
	localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
	localparam int unsigned AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

	// configuration
	logic        en_q;
	mode_t       mode_q;
	logic [15:0] len_q;
	logic [6:0]  pct_q;
	logic [23:0] prod_q;
	logic [31:0] budget_q;

	// request
	op_t         op_q;
	logic [30:0] strokes_q;
	logic [31:0] start_q;
	logic [31:0] now_q;

	// plan
	logic        active_q;
	kind_t       kind_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [6:0]  stride_q;
	logic [30:0] cad_q;
	logic        trig_q;

	// fill
	logic [CW-1:0]  k_q;
	logic [31:0]    acc_q;
	logic [DVW-1:0] accr_q;
	logic [31:0]    bq_q;
	logic [DVW-1:0] br_q;

	// result
	logic        out_valid_q;
	logic        out_trig_q;
	logic        out_act_q;
	kind_t       out_kind_q;
	logic [6:0]  out_idx_q;
	logic [6:0]  out_cnt_q;

	logic [DDW-1:0] div_dividend;
	logic [DVW-1:0] div_divisor;
	logic           div_done;
	logic [DDW-1:0] div_quo;
	logic [DVW-1:0] div_rem;
	logic [47:0]    cnt_prod;
	logic [16:0]    cnt_quo;
	logic [CW-1:0]  count_next;
	logic [DVW:0]   rsum;
	logic           carry;
	logic [30:0]    mval;
	logic [30:0]    rdata;
	logic [31:0]    cad_sum;
	logic           pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			mode_q <= MODE_STROKES;
			len_q  <= '0;
			pct_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE: en_q   <= cfg_data[0];
				REG_MODE:   mode_q <= mode_t'(cfg_data[1:0]);
				REG_LENGTH: len_q  <= cfg_data;
				REG_SHARE:  pct_q  <= cfg_data[6:0];
			endcase
		end
	end

	// products registered ahead of the count multiply and the divider
	always_ff @(posedge clk) begin
		prod_q   <= 24'(len_q) * 24'(pct_q) + 24'(PCT_HALF);
		budget_q <= len_q * MS_PER_MIN;
	end

	// rounded milestone count: reciprocal multiply by 1/100
	assign cnt_prod = 48'(prod_q) * 48'(PCT_RECIP);
	assign cnt_quo  = cnt_prod[PCT_SHIFT+16:PCT_SHIFT];

	always_comb begin
		unique case (cmd.div_sel)
			DIV_SPAN: begin
				div_dividend = (mode_q == MODE_STROKES) ? 32'(len_q) : budget_q;
				div_divisor  = DVW'(count_q);
			end
			default: begin
				div_dividend = 32'(8'd100 + 8'(pct_q >> 1));
				div_divisor  = DVW'(pct_q);
			end
		endcase
	end

	bes_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign count_next = (cnt_quo > 17'(MAX_EVENTS)) ? CW'(MAX_EVENTS) : CW'(cnt_quo);

	// running floor(k*B/n): quotient and remainder stepped by B div n and B mod n
	assign rsum  = {1'b0, accr_q} + {1'b0, br_q};
	assign carry = rsum >= {1'b0, DVW'(count_q)};
	assign mval  = (mode_q == MODE_STROKES) ? ((acc_q == 32'd0) ? 31'd1 : acc_q[30:0])
		: ((acc_q > {1'b0, MAX31}) ? MAX31 : acc_q[30:0]);

	bes_ram #(.WIDTH(31), .DEPTH(MAX_EVENTS)) u_table (
		.clk   (clk),
		.we    (cmd.fill_step),
		.waddr (k_q[AW-1:0]),
		.wdata (mval),
		.re    (cmd.mem_read),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	assign pending = idx_q < count_q;
	assign cad_sum = {1'b0, cad_q} + 32'(stride_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= op_t'(item.op);
			strokes_q <= item.strokes_done;
			start_q   <= item.start_ms;
			now_q     <= item.current_ms;
		end
		if (cmd.fill_init) begin
			acc_q  <= div_quo;
			accr_q <= div_rem;
			bq_q   <= div_quo;
			br_q   <= div_rem;
		end else if (cmd.fill_step) begin
			acc_q  <= acc_q + bq_q + 32'(carry);
			accr_q <= carry ? DVW'(rsum - {1'b0, DVW'(count_q)}) : DVW'(rsum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			kind_q   <= KIND_NONE;
			count_q  <= '0;
			idx_q    <= '0;
			stride_q <= '0;
			cad_q    <= '0;
			trig_q   <= 1'b0;
			k_q      <= '0;
		end else begin
			if (cmd.load) begin
				trig_q <= 1'b0;
			end
			if (cmd.clear) begin
				active_q <= 1'b0;
				kind_q   <= KIND_NONE;
				count_q  <= '0;
				idx_q    <= '0;
				stride_q <= '0;
				cad_q    <= '0;
			end
			if (cmd.set_count) begin
				count_q <= count_next;
			end
			if (cmd.fill_init) begin
				k_q <= '0;
			end else if (cmd.fill_step) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.set_plan) begin
				active_q <= 1'b1;
				kind_q   <= (mode_q == MODE_STROKES) ? KIND_STROKES : KIND_CLOCK;
			end
			if (cmd.set_stride && (div_quo != 32'd0)) begin
				active_q <= 1'b1;
				kind_q   <= KIND_CADENCE;
				stride_q <= 7'(div_quo);
				cad_q    <= 31'(div_quo);
			end
			if (cmd.check && active_q) begin
				if (op_q == OP_STROKE) begin
					if (kind_q == KIND_STROKES) begin
						trig_q <= pending && (strokes_q >= rdata);
					end else if (kind_q == KIND_CADENCE) begin
						trig_q <= (cad_q != 31'd0) && (strokes_q >= cad_q);
					end
				end else if (kind_q == KIND_CLOCK && start_q != 32'd0) begin
					trig_q <= pending && ({1'b0, now_q} >= ({1'b0, start_q} + 33'(rdata)));
				end
			end
			if (cmd.advance && active_q) begin
				if (kind_q == KIND_STROKES || kind_q == KIND_CLOCK) begin
					if (pending) begin
						idx_q <= idx_q + 1'b1;
					end
				end else if (kind_q == KIND_CADENCE) begin
					cad_q <= (cad_sum > {1'b0, MAX31}) ? MAX31 : cad_sum[30:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_trig_q <= trig_q;
			out_act_q  <= active_q;
			out_kind_q <= kind_q;
			out_idx_q  <= 7'(idx_q);
			out_cnt_q  <= 7'(count_q);
		end
	end

	assign item.ready              = cmd.ready;
	assign result.valid            = out_valid_q;
	assign result.trigger          = out_trig_q;
	assign result.plan_active      = out_act_q;
	assign result.plan_kind        = out_kind_q;
	assign result.next_event_index = out_idx_q;
	assign result.event_total      = out_cnt_q;

	assign sts.op        = op_q;
	assign sts.mode      = mode_q;
	assign sts.skip      = !en_q || (pct_q == 7'd0);
	assign sts.len_zero  = len_q == 16'd0;
	assign sts.div_done  = div_done;
	assign sts.cnt_zero  = count_next == '0;
	assign sts.fill_last = k_q == (count_q - 1'b1);
	assign sts.out_free  = !out_valid_q || result.ready;
endmodule
`default_nettype wire

>>> sv/bes_controller.sv
// Sequencer for build, check and advance requests.
// Depends on bes_pkg.
`default_nettype none
module bes_controller import bes_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire status_t sts,
	output cmd_t         cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_BUILD: begin
						cmd.clear = 1'b1;
						state_d   = S_EMIT;
						if (!sts.skip) begin
							unique case (sts.mode)
								MODE_STROKES, MODE_MINUTES: begin
									if (!sts.len_zero) begin
										state_d = S_CNT_WAIT;
									end
								end
								MODE_ENDLESS: begin
									cmd.div_start = 1'b1;
									cmd.div_sel   = DIV_STRIDE;
									state_d       = S_STR_WAIT;
								end
								MODE_NONE: state_d = S_EMIT;
							endcase
						end
					end
					OP_STROKE, OP_TIME: begin
						cmd.mem_read = 1'b1;
						state_d      = S_CHECK;
					end
					OP_ADVANCE: begin
						cmd.advance = 1'b1;
						state_d     = S_EMIT;
					end
				endcase
			end
			S_CNT_WAIT: begin
				cmd.set_count = 1'b1;
				state_d       = sts.cnt_zero ? S_EMIT : S_SPAN_GO;
			end
			S_SPAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SPAN;
				state_d       = S_SPAN_WAIT;
			end
			S_SPAN_WAIT: begin
				cmd.div_sel = DIV_SPAN;
				if (sts.div_done) begin
					cmd.fill_init = 1'b1;
					state_d       = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					cmd.set_plan = 1'b1;
					state_d      = S_EMIT;
				end
			end
			S_STR_WAIT: begin
				cmd.div_sel = DIV_STRIDE;
				if (sts.div_done) begin
					cmd.set_stride = 1'b1;
					state_d        = S_EMIT;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> sv/bes_checker.sv
// Port-level checks on the burst event scheduler, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bes_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       trigger,
	input wire logic       plan_active,
	input wire logic [1:0] plan_kind,
	input wire logic [6:0] next_event_index,
	input wire logic [6:0] event_total
);
	`ASSERT_CLK(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
	`ASSERT_IMP(a_trig_active, clk, arst_n, out_valid && trigger, plan_active, "trigger with no plan")
	`ASSERT_IMP(a_idle_plan, clk, arst_n, out_valid && !plan_active, (plan_kind == 2'd0) && (event_total == 7'd0) && (next_event_index == 7'd0), "inactive plan not clear")
	`ASSERT_IMP(a_cadence, clk, arst_n, out_valid && (plan_kind == 2'd3), event_total == 7'd0, "cadence plan with milestones")
endmodule

bind burst_event_scheduler bes_checker u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.trigger          (result.trigger),
	.plan_active      (result.plan_active),
	.plan_kind        (result.plan_kind),
	.next_event_index (result.next_event_index),
	.event_total      (result.event_total)
);
`default_nettype wire
